@@ design/sinpe_pkg.sv @@
// Package for the sinusoidal position encoding adder: payload structs, sizes,
// and the frequency, arctangent and gain constants, built at elaboration.
// Depends on nothing; every design file imports it.
package sinpe_pkg;

	localparam int PE_DIMS         = 64;
	localparam int MAX_POSITIONS   = 2048;
	localparam int CORDIC_STEPS    = 16;
	localparam int ATAN_ENTRIES    = 24;
	localparam int FREQ_ENTRIES    = (PE_DIMS + 1) / 2;
	localparam int FREQ_IDX_W      = (FREQ_ENTRIES > 1) ? $clog2(FREQ_ENTRIES) : 1;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int CORDIC_W        = 34;
	localparam int SUM_W           = 35;

	localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565275;
	localparam logic [63:0] LOG2_10000_Q32 = 64'd57070290109;
	localparam logic [16:0] JACOBIAN_ONE   = 17'd65536;
	localparam int          ROUND_Q14      = 8192;
	localparam int          CODE_SHIFT     = 14;

	localparam logic [1:0] QUAD_ZERO  = 2'd0;
	localparam logic [1:0] QUAD_ONE   = 2'd1;
	localparam logic [1:0] QUAD_TWO   = 2'd2;
	localparam logic [1:0] QUAD_THREE = 2'd3;

	typedef struct packed {
		logic [10:0]        position;
		logic [5:0]         dim_index;
		logic signed [31:0] mu_in;
		logic [31:0]        var_in;
	} item_t;

	typedef struct packed {
		logic signed [31:0] mu_out;
		logic [31:0]        var_out;
		logic [16:0]        jacobian;
	} result_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
	} cordic_vec_t;

	typedef logic [FREQ_ENTRIES-1:0][31:0] freq_rom_t;
	typedef logic [ATAN_ENTRIES-1:0][31:0] atan_rom_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// Restoring long division, used only while building constants.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = 64'd0;
		quo = 64'd0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[62:0], num[k]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic freq_rom_t build_freq_rom();
		freq_rom_t   rom;
		logic [63:0] root [33];
		logic [63:0] e;
		logic [63:0] f;
		logic [63:0] m;
		int          n;
		root[0] = 64'd0;
		root[1] = isqrt64(64'd1 << 63);
		for (int i = 2; i <= 32; i++) begin
			root[i] = isqrt64(root[i-1] << 32);
		end
		for (int k = 0; k < FREQ_ENTRIES; k++) begin
			e = (64'(2 * k) * LOG2_10000_Q32) / 64'(PE_DIMS);
			n = int'(e >> 32);
			f = e & 64'hFFFF_FFFF;
			m = 64'd1 << 32;
			for (int i = 1; i <= 32; i++) begin
				if (f[32-i]) begin
					m = (m * root[i]) >> 32;
				end
			end
			rom[k] = 32'((m * INV_TWO_PI_Q32) >> (32 + n));
		end
		return rom;
	endfunction

	function automatic atan_rom_t build_atan_rom();
		atan_rom_t          rom;
		logic signed [63:0] s;
		logic signed [63:0] term;
		logic [63:0]        us;
		rom[0] = 32'd1 << 29;
		for (int i = 1; i < ATAN_ENTRIES; i++) begin
			s = 64'sd0;
			for (int t = 0; t < 32; t++) begin
				if (i * (2 * t + 1) <= 62) begin
					term = $signed(udiv64(64'd1 << (62 - i * (2 * t + 1)), 64'(2 * t + 1)));
					if (t % 2 == 1) begin
						s = s - term;
					end else begin
						s = s + term;
					end
				end
			end
			us     = $unsigned(s);
			rom[i] = 32'(((us >> 31) * INV_TWO_PI_Q32) >> 31);
		end
		return rom;
	endfunction

	function automatic logic [63:0] build_gain_q30();
		logic [63:0] g;
		logic [63:0] v;
		logic [63:0] s;
		logic [63:0] inv;
		g = 64'd1 << 31;
		for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
			v   = (64'd1 << 62) + (64'd1 << (62 - 2 * i));
			s   = isqrt64(v);
			inv = udiv64(64'd1 << 62, s);
			g   = (g * inv) >> 31;
		end
		return g >> 1;
	endfunction

	localparam freq_rom_t   FREQ_ROM        = build_freq_rom();
	localparam atan_rom_t   ATAN_ROM        = build_atan_rom();
	localparam logic [63:0] CORDIC_GAIN_Q30 = build_gain_q30();

endpackage

@@ design/sinusoidal_position_encoding_adder_unit.sv @@
// Top level of the sinusoidal position encoding adder: angle multiply, CORDIC
// pipeline (two rotations per stage), and saturating add of the code to the mean.
// Depends on sinpe_pkg.
//
// Path of an item: input, angle, CORDIC input, CORDIC stage, select and result registers.
// Throughput: one transaction per cycle; busy is always low and the pipeline never stalls.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module sinusoidal_position_encoding_adder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sinpe_pkg::item_t  item,
	output logic              done,
	output sinpe_pkg::result_t result
);
	import sinpe_pkg::*;

	logic                      valid_s1;
	item_t                     item_s1;

	logic                      valid_s2;
	logic [31:0]               angle_s2;
	logic                      odd_s2;
	logic                      en_s2;
	logic signed [31:0]        mu_s2;
	logic [31:0]               var_s2;

	logic                      valid_s3 [CORDIC_STAGES+1];
	cordic_vec_t               vec_s3   [CORDIC_STAGES+1];
	logic [1:0]                quad_s3  [CORDIC_STAGES+1];
	logic                      odd_s3   [CORDIC_STAGES+1];
	logic                      en_s3    [CORDIC_STAGES+1];
	logic signed [31:0]        mu_s3    [CORDIC_STAGES+1];
	logic [31:0]               var_s3   [CORDIC_STAGES+1];

	logic                      valid_s4;
	logic signed [CORDIC_W-1:0] sel_s4;
	logic                      en_s4;
	logic signed [31:0]        mu_s4;
	logic [31:0]               var_s4;

	logic                      done_q;
	result_t                   result_q;

	logic                      accept;
	logic [FREQ_IDX_W-1:0]     freq_idx;
	logic [31:0]               angle_prod;
	logic                      in_range;
	logic [31:0]               angle_rnd;
	logic [1:0]                quad;
	logic [31:0]               resid;
	cordic_vec_t               vec_init;
	logic signed [CORDIC_W-1:0] cos_v;
	logic signed [CORDIC_W-1:0] sin_v;
	logic signed [CORDIC_W-1:0] rounded;
	logic signed [SUM_W-1:0]   sum;
	logic signed [31:0]        mu_sat;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		freq_idx   = FREQ_IDX_W'({1'b0, item_s1.dim_index[5:1]});
		angle_prod = 32'(item_s1.position) * FREQ_ROM[freq_idx];
		in_range   = (32'(item_s1.dim_index) < 32'(PE_DIMS)) &&
		             (32'(item_s1.position) < 32'(MAX_POSITIONS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		angle_s2 <= angle_prod;
		odd_s2   <= item_s1.dim_index[0];
		en_s2    <= in_range;
		mu_s2    <= item_s1.mu_in;
		var_s2   <= item_s1.var_in;
	end

	always_comb begin
		angle_rnd  = angle_s2 + 32'h2000_0000;
		quad       = angle_rnd[31:30];
		resid      = angle_s2 - {quad, 30'd0};
		vec_init.x = $signed(CORDIC_GAIN_Q30[CORDIC_W-1:0]);
		vec_init.y = '0;
		vec_init.z = $signed({{(CORDIC_W-32){resid[31]}}, resid});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3[0] <= 1'b0;
		end else begin
			valid_s3[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		vec_s3[0]  <= vec_init;
		quad_s3[0] <= quad;
		odd_s3[0]  <= odd_s2;
		en_s3[0]   <= en_s2;
		mu_s3[0]   <= mu_s2;
		var_s3[0]  <= var_s2;
	end

	for (genvar j = 1; j <= CORDIC_STAGES; j++) begin : g_cordic
		cordic_vec_t vec_next;

		always_comb begin
			logic signed [CORDIC_W-1:0] dx;
			logic signed [CORDIC_W-1:0] dy;
			logic signed [CORDIC_W-1:0] at;
			int                         st;
			vec_next = vec_s3[j-1];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				st = (j - 1) * STEPS_PER_STAGE + k;
				if (st < CORDIC_STEPS && st < ATAN_ENTRIES) begin
					dx = vec_next.y >>> st;
					dy = vec_next.x >>> st;
					at = $signed({{(CORDIC_W-32){1'b0}}, ATAN_ROM[st]});
					if (vec_next.z >= 0) begin
						vec_next.x = vec_next.x - dx;
						vec_next.y = vec_next.y + dy;
						vec_next.z = vec_next.z - at;
					end else begin
						vec_next.x = vec_next.x + dx;
						vec_next.y = vec_next.y - dy;
						vec_next.z = vec_next.z + at;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s3[j] <= 1'b0;
			end else begin
				valid_s3[j] <= valid_s3[j-1];
			end
		end

		always_ff @(posedge clk) begin
			vec_s3[j]  <= vec_next;
			quad_s3[j] <= quad_s3[j-1];
			odd_s3[j]  <= odd_s3[j-1];
			en_s3[j]   <= en_s3[j-1];
			mu_s3[j]   <= mu_s3[j-1];
			var_s3[j]  <= var_s3[j-1];
		end
	end

	always_comb begin
		case (quad_s3[CORDIC_STAGES])
			QUAD_ZERO: begin
				cos_v = vec_s3[CORDIC_STAGES].x;
				sin_v = vec_s3[CORDIC_STAGES].y;
			end
			QUAD_ONE: begin
				cos_v = -vec_s3[CORDIC_STAGES].y;
				sin_v = vec_s3[CORDIC_STAGES].x;
			end
			QUAD_TWO: begin
				cos_v = -vec_s3[CORDIC_STAGES].x;
				sin_v = -vec_s3[CORDIC_STAGES].y;
			end
			default: begin
				cos_v = vec_s3[CORDIC_STAGES].y;
				sin_v = -vec_s3[CORDIC_STAGES].x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sel_s4 <= odd_s3[CORDIC_STAGES] ? cos_v : sin_v;
		en_s4  <= en_s3[CORDIC_STAGES];
		mu_s4  <= mu_s3[CORDIC_STAGES];
		var_s4 <= var_s3[CORDIC_STAGES];
	end

	always_comb begin
		rounded = (sel_s4 + CORDIC_W'(ROUND_Q14)) >>> CODE_SHIFT;
		if (!en_s4) begin
			rounded = '0;
		end
		sum = $signed({{(SUM_W-32){mu_s4[31]}}, mu_s4}) +
		      $signed({{(SUM_W-CORDIC_W){rounded[CORDIC_W-1]}}, rounded});
		if (sum > $signed(SUM_W'(32'sh7FFF_FFFF))) begin
			mu_sat = 32'sh7FFF_FFFF;
		end else if (sum < -$signed(SUM_W'(64'sh8000_0000))) begin
			mu_sat = $signed(32'h8000_0000);
		end else begin
			mu_sat = sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		result_q.mu_out   <= mu_sat;
		result_q.var_out  <= var_s4;
		result_q.jacobian <= JACOBIAN_ONE;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
